@@ hdl/humidity_sensor_pulse_decoder_core_macros.svh @@
// Assertion macros shared by the decoder modules.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef HUMIDITY_SENSOR_PULSE_DECODER_CORE_MACROS_SVH
`define HUMIDITY_SENSOR_PULSE_DECODER_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define HSPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HSPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hspd_pkg.sv @@
package hspd_pkg;

    localparam int FRAME_W     = 40;
    localparam int COUNT_W     = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int HUM_W       = 12;
    localparam int TC_W        = 13;
    localparam int TF_W        = 14;

    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_EDGES     = 2'd2;

    localparam logic [7:0] BIT_THRESHOLD_RST = 8'd16;
    localparam logic [7:0] TIMEOUT_LIMIT_RST = 8'd255;
    localparam logic [7:0] MAX_EDGES_RST     = 8'd200;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_START  = 1'b1;

    localparam logic [COUNT_W-1:0] FULL_BITS       = 6'd40;
    localparam logic [7:0]         FIRST_DATA_EDGE = 8'd4;

    localparam logic [15:0] HUM_LIMIT  = 16'd1000;
    localparam logic [14:0] TEMP_LIMIT = 15'd1250;

    // 5*F = 9*C + 1600, biased so the quotient stays non-negative, plus 2 to round.
    localparam logic signed [16:0] F_BIAS   = 17'sd26602;
    localparam logic [15:0]        RECIP5   = 16'd52429;
    localparam int                 RECIP_SH = 18;
    localparam logic [TF_W-1:0]    F_OFFSET = 14'd5000;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
        logic               tmo;
    } hspd_snap_t;

    typedef struct packed {
        logic [FRAME_W-1:0]    frame;
        logic [COUNT_W-1:0]    count;
        logic                  ok;
        logic                  valid;
        logic                  tmo;
        logic [HUM_W-1:0]      hum;
        logic signed [TC_W-1:0] tc;
    } hspd_dec_t;

endpackage

@@ hdl/hspd_if.sv @@
interface hspd_in_if;
    logic valid;
    logic ready;
    logic req_type;
    logic pin_level;

    modport source (output valid, output req_type, output pin_level, input ready);
    modport sink (input valid, input req_type, input pin_level, output ready);
endinterface

interface hspd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [hspd_pkg::CFG_INDEX_W-1:0]   index;
    logic [7:0]                         data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface hspd_out_if;
    logic                               valid;
    logic                               ready;
    logic [hspd_pkg::FRAME_W-1:0]       raw_frame;
    logic [hspd_pkg::COUNT_W-1:0]       bits_received;
    logic                               checksum_ok;
    logic                               frame_valid;
    logic                               timed_out;
    logic [hspd_pkg::HUM_W-1:0]         humidity_tenths;
    logic signed [hspd_pkg::TC_W-1:0]   temp_c_tenths;
    logic signed [hspd_pkg::TF_W-1:0]   temp_f_tenths;

    modport source (
        output valid, output raw_frame, output bits_received, output checksum_ok,
        output frame_valid, output timed_out, output humidity_tenths,
        output temp_c_tenths, output temp_f_tenths, input ready
    );
    modport sink (
        input valid, input raw_frame, input bits_received, input checksum_ok,
        input frame_valid, input timed_out, input humidity_tenths,
        input temp_c_tenths, input temp_f_tenths, output ready
    );
endinterface

@@ hdl/humidity_sensor_pulse_decoder_core.sv @@
// Path: the item that ends a read is registered, its state update goes into a snapshot
// register, byte decode into a decode register, Fahrenheit scaling into the output register.
// Throughput: one item per cycle; the output pipeline only stalls input when it is full.
// Reset: configuration returns to threshold 16, timeout 255, max edges 200, and the
// decoder returns to idle with an empty frame and no result pending.
`include "humidity_sensor_pulse_decoder_core_macros.svh"

module humidity_sensor_pulse_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    hspd_in_if.sink    item,
    hspd_cfg_if.sink   cfg,
    hspd_out_if.source result
);

    logic [7:0] bit_threshold_reg;
    logic [7:0] timeout_limit_reg;
    logic [7:0] max_edges_reg;

    logic a_valid_reg;
    logic a_req_reg;
    logic a_pin_reg;
    logic a_adv;

    logic                          busy_reg,        busy_next;
    logic                          last_level_reg,  last_level_next;
    logic [7:0]                    run_length_reg,  run_length_next;
    logic [7:0]                    edge_index_reg,  edge_index_next;
    logic [hspd_pkg::COUNT_W-1:0]  bit_count_reg,   bit_count_next;
    logic [hspd_pkg::FRAME_W-1:0]  frame_reg,       frame_next;

    logic [7:0]                    run_inc;
    logic [7:0]                    edge_inc;
    logic                          new_bit;
    logic                          shift_en;
    logic [hspd_pkg::FRAME_W-1:0]  frame_shifted;
    logic                          emit;
    logic                          emit_tmo;

    logic                 snap_valid;
    logic                 snap_ready;
    hspd_pkg::hspd_snap_t snap;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_threshold_reg <= hspd_pkg::BIT_THRESHOLD_RST;
            timeout_limit_reg <= hspd_pkg::TIMEOUT_LIMIT_RST;
            max_edges_reg     <= hspd_pkg::MAX_EDGES_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                hspd_pkg::CFG_BIT_THRESHOLD: bit_threshold_reg <= cfg.data;
                hspd_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg.data;
                hspd_pkg::CFG_MAX_EDGES:     max_edges_reg     <= cfg.data;
                default:                     ;
            endcase
        end
    end

    assign run_inc  = run_length_reg + 8'd1;
    assign edge_inc = edge_index_reg + 8'd1;
    assign new_bit  = run_length_reg > bit_threshold_reg;
    assign shift_en = (edge_index_reg >= hspd_pkg::FIRST_DATA_EDGE) && !edge_index_reg[0]
                      && (bit_count_reg < hspd_pkg::FULL_BITS);

    // Bit n goes into byte n/8, entering that byte from the right.
    always_comb
    begin
        frame_shifted = frame_reg;
        for (int k = 0; k < 5; k++)
        begin
            if (bit_count_reg[5:3] == 3'(k))
            begin
                frame_shifted[39-8*k -: 8] = {frame_reg[38-8*k -: 7], new_bit};
            end
        end
    end

    always_comb
    begin
        busy_next       = busy_reg;
        last_level_next = last_level_reg;
        run_length_next = run_length_reg;
        edge_index_next = edge_index_reg;
        bit_count_next  = bit_count_reg;
        frame_next      = frame_reg;
        emit            = 1'b0;
        emit_tmo        = 1'b0;

        if (a_valid_reg)
        begin
            if (a_req_reg == hspd_pkg::REQ_START)
            begin
                busy_next       = 1'b1;
                last_level_next = 1'b1;
                run_length_next = '0;
                edge_index_next = '0;
                bit_count_next  = '0;
                frame_next      = '0;
            end
            else if (busy_reg)
            begin
                if (a_pin_reg == last_level_reg)
                begin
                    run_length_next = run_inc;
                    if (run_inc == timeout_limit_reg)
                    begin
                        emit      = 1'b1;
                        emit_tmo  = 1'b1;
                        busy_next = 1'b0;
                    end
                end
                else
                begin
                    if (shift_en)
                    begin
                        frame_next     = frame_shifted;
                        bit_count_next = bit_count_reg + 6'd1;
                    end
                    edge_index_next = edge_inc;
                    last_level_next = a_pin_reg;
                    run_length_next = '0;
                    if (edge_inc == max_edges_reg)
                    begin
                        emit      = 1'b1;
                        busy_next = 1'b0;
                    end
                end
            end
        end
    end

    assign a_adv      = a_valid_reg && (!emit || snap_ready);
    assign item.ready = !a_valid_reg || a_adv;

    assign snap_valid = a_valid_reg && emit;
    assign snap.frame = frame_next;
    assign snap.count = bit_count_next;
    assign snap.tmo   = emit_tmo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            busy_reg       <= 1'b0;
            last_level_reg <= 1'b1;
            run_length_reg <= '0;
            edge_index_reg <= '0;
            bit_count_reg  <= '0;
            frame_reg      <= '0;
        end
        else
        begin
            if (item.ready)
            begin
                a_valid_reg <= item.valid;
            end
            if (a_adv)
            begin
                busy_reg       <= busy_next;
                last_level_reg <= last_level_next;
                run_length_reg <= run_length_next;
                edge_index_reg <= edge_index_next;
                bit_count_reg  <= bit_count_next;
                frame_reg      <= frame_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            a_req_reg <= item.req_type;
            a_pin_reg <= item.pin_level;
        end
    end

    hspd_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .result     (result)
    );

    `HSPD_ASSERT_SAME(a_count_range, 1'b1, bit_count_reg <= hspd_pkg::FULL_BITS, "bit count beyond forty")
    `HSPD_ASSERT_NEXT(a_start_clears, a_adv && a_req_reg == hspd_pkg::REQ_START, busy_reg && bit_count_reg == '0 && frame_reg == '0 && edge_index_reg == '0, "start did not clear the read")
    `HSPD_ASSERT_SAME(a_idle_silent, a_valid_reg && a_req_reg == hspd_pkg::REQ_SAMPLE && !busy_reg, !snap_valid, "result raised while idle")

endmodule

@@ hdl/hspd_result.sv @@
`include "humidity_sensor_pulse_decoder_core_macros.svh"

module hspd_result (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 snap_valid,
    output logic                 snap_ready,
    input  hspd_pkg::hspd_snap_t snap,
    hspd_out_if.source           result
);

    logic                 b_valid_reg;
    hspd_pkg::hspd_snap_t b_snap_reg;
    logic                 c_valid_reg;
    hspd_pkg::hspd_dec_t  c_dec_reg;
    logic                 d_valid_reg;

    logic b_free;
    logic c_free;
    logic d_free;

    logic [7:0]                      d0, d1, d2, d3, d4;
    logic [9:0]                      byte_sum;
    logic [15:0]                     hum_raw;
    logic [14:0]                     mag_raw;
    logic [hspd_pkg::HUM_W-1:0]      hum_alt;
    logic [hspd_pkg::HUM_W-1:0]      mag_alt;
    logic [hspd_pkg::HUM_W-1:0]      mag;
    hspd_pkg::hspd_dec_t             dec_next;

    logic signed [16:0]              tc_ext;
    logic signed [16:0]              f_scaled;
    logic [31:0]                     f_prod;
    logic [hspd_pkg::TF_W-1:0]       tf_next;

    assign d_free     = !d_valid_reg || result.ready;
    assign c_free     = !c_valid_reg || d_free;
    assign b_free     = !b_valid_reg || c_free;
    assign snap_ready = b_free;

    assign d0 = b_snap_reg.frame[39:32];
    assign d1 = b_snap_reg.frame[31:24];
    assign d2 = b_snap_reg.frame[23:16];
    assign d3 = b_snap_reg.frame[15:8];
    assign d4 = b_snap_reg.frame[7:0];

    always_comb
    begin
        byte_sum = {2'b00, d0} + {2'b00, d1} + {2'b00, d2} + {2'b00, d3};
        hum_raw  = {d0, d1};
        mag_raw  = {d2[6:0], d3};
        hum_alt  = ({4'b0000, d0} << 3) + ({4'b0000, d0} << 1);
        mag_alt  = ({4'b0000, d2} << 3) + ({4'b0000, d2} << 1);

        dec_next.frame = b_snap_reg.frame;
        dec_next.count = b_snap_reg.count;
        dec_next.tmo   = b_snap_reg.tmo;
        dec_next.ok    = (d4 == byte_sum[7:0]);
        dec_next.valid = dec_next.ok && (b_snap_reg.count == hspd_pkg::FULL_BITS);

        if (hum_raw > hspd_pkg::HUM_LIMIT)
        begin
            dec_next.hum = hum_alt;
        end
        else
        begin
            dec_next.hum = hum_raw[11:0];
        end

        if (mag_raw > hspd_pkg::TEMP_LIMIT)
        begin
            mag = mag_alt;
        end
        else
        begin
            mag = mag_raw[11:0];
        end

        if (d2[7])
        begin
            dec_next.tc = -$signed({1'b0, mag});
        end
        else
        begin
            dec_next.tc = $signed({1'b0, mag});
        end

        if (!dec_next.valid)
        begin
            dec_next.hum = '0;
            dec_next.tc  = '0;
        end
    end

    always_comb
    begin
        tc_ext   = {{4{c_dec_reg.tc[12]}}, c_dec_reg.tc};
        f_scaled = (tc_ext <<< 3) + tc_ext + hspd_pkg::F_BIAS;
        f_prod   = 32'(f_scaled[15:0]) * 32'(hspd_pkg::RECIP5);
        if (c_dec_reg.valid)
        begin
            tf_next = f_prod[31:hspd_pkg::RECIP_SH] - hspd_pkg::F_OFFSET;
        end
        else
        begin
            tf_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_free)
            begin
                b_valid_reg <= snap_valid;
            end
            if (c_free)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_free)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_free && snap_valid)
        begin
            b_snap_reg <= snap;
        end
        if (c_free && b_valid_reg)
        begin
            c_dec_reg <= dec_next;
        end
        if (d_free && c_valid_reg)
        begin
            result.raw_frame       <= c_dec_reg.frame;
            result.bits_received   <= c_dec_reg.count;
            result.checksum_ok     <= c_dec_reg.ok;
            result.frame_valid     <= c_dec_reg.valid;
            result.timed_out       <= c_dec_reg.tmo;
            result.humidity_tenths <= c_dec_reg.hum;
            result.temp_c_tenths   <= c_dec_reg.tc;
            result.temp_f_tenths   <= $signed(tf_next);
        end
    end

    assign result.valid = d_valid_reg;

    `HSPD_ASSERT_SAME(a_valid_needs_full, d_valid_reg && result.frame_valid, result.bits_received == hspd_pkg::FULL_BITS && result.checksum_ok, "valid frame without forty bits and good checksum")
    `HSPD_ASSERT_SAME(a_invalid_zero, d_valid_reg && !result.frame_valid, result.humidity_tenths == '0 && result.temp_c_tenths == '0 && result.temp_f_tenths == '0, "readings not cleared on invalid frame")
    `HSPD_ASSERT_SAME(a_f_above_freeze, d_valid_reg && result.frame_valid && result.temp_c_tenths >= 0, result.temp_f_tenths >= 14'sd320, "Fahrenheit below freezing for non-negative Celsius")

endmodule

@@ bench/humidity_sensor_pulse_decoder_core_test.sv @@
`timescale 1ns / 100ps

module humidity_sensor_pulse_decoder_core_test;

    localparam logic [hspd_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic req;
        logic pin;
    } pin_item_t;

    typedef struct packed {
        logic [hspd_pkg::FRAME_W-1:0] frame;
        logic [hspd_pkg::COUNT_W-1:0] nbits;
        logic                         ok;
        logic                         valid;
        logic                         tmo;
        logic [hspd_pkg::HUM_W-1:0]   hum;
        logic [hspd_pkg::TC_W-1:0]    tc;
        logic [hspd_pkg::TF_W-1:0]    tf;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n;

    hspd_in_if  item_ch ();
    hspd_cfg_if cfg_ch ();
    hspd_out_if res_ch ();

    humidity_sensor_pulse_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .cfg    (cfg_ch.sink),
        .result (res_ch.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pin_item_t pin_samples[$];
    reading_t  expected_readings[$];

    logic [7:0]                   thr_reg;
    logic [7:0]                   tmo_reg;
    logic [7:0]                   edges_reg;
    logic                         busy;
    logic                         last_lvl;
    logic [7:0]                   run_len;
    logic [7:0]                   edge_idx;
    logic [hspd_pkg::COUNT_W-1:0] nbits;
    logic [hspd_pkg::FRAME_W-1:0] frame_bits;

    logic item_taken = 1'b0;
    int   mismatches = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_off_len = 0;
    int   hold_requests = 0;
    int   hold_grants = 0;
    int   hold_left = 0;
    int   thr_set = int'(hspd_pkg::BIT_THRESHOLD_RST);
    int   tmo_set = int'(hspd_pkg::TIMEOUT_LIMIT_RST);
    int   edges_set = int'(hspd_pkg::MAX_EDGES_RST);

    function automatic reading_t close_read(input logic timed);
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] d3;
        logic [7:0] d4;
        int         hum;
        int         mag;
        int         tc;
        int         tf;
        reading_t   r;
        {d0, d1, d2, d3, d4} = frame_bits;
        r.frame = frame_bits;
        r.nbits = nbits;
        r.ok = (d4 == 8'(d0 + d1 + d2 + d3));
        r.valid = r.ok && (nbits >= hspd_pkg::FULL_BITS);
        r.tmo = timed;
        hum = 0;
        tc = 0;
        tf = 0;
        if (r.valid)
        begin
            hum = int'(d0) * 256 + int'(d1);
            if (hum > 1000)
                hum = int'(d0) * 10;
            mag = int'(d2[6:0]) * 256 + int'(d3);
            if (mag > 1250)
                mag = int'(d2) * 10;
            tc = d2[7] ? -mag : mag;
            // The bias keeps the numerator positive, so the division rounds to nearest.
            tf = (9 * tc + 26602) / 5 - 5000;
        end
        r.hum = hum[hspd_pkg::HUM_W-1:0];
        r.tc = tc[hspd_pkg::TC_W-1:0];
        r.tf = tf[hspd_pkg::TF_W-1:0];
        busy = 1'b0;
        return r;
    endfunction

    task automatic shift_bit(input logic b);
        int sh;
        if (nbits < hspd_pkg::FULL_BITS)
        begin
            sh = 32 - 8 * (int'(nbits) / 8);
            frame_bits[sh +: 8] = {frame_bits[sh +: 7], b};
            nbits = nbits + hspd_pkg::COUNT_W'(1);
        end
    endtask

    task automatic decode_sample(input logic req, input logic pin);
        if (req == hspd_pkg::REQ_START)
        begin
            busy = 1'b1;
            last_lvl = 1'b1;
            run_len = '0;
            edge_idx = '0;
            nbits = '0;
            frame_bits = '0;
        end
        else if (busy)
        begin
            if (pin == last_lvl)
            begin
                run_len = run_len + 8'd1;
                if (run_len == tmo_reg)
                    expected_readings.push_back(close_read(1'b1));
            end
            else
            begin
                if (edge_idx >= hspd_pkg::FIRST_DATA_EDGE && !edge_idx[0])
                    shift_bit(run_len > thr_reg);
                edge_idx = edge_idx + 8'd1;
                last_lvl = pin;
                run_len = '0;
                if (edge_idx == edges_reg)
                    expected_readings.push_back(close_read(1'b0));
            end
        end
    endtask

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_reading();
        reading_t want;
        if (expected_readings.size() == 0)
        begin
            $error("result transfer with no reading expected");
            mismatches++;
        end
        else
        begin
            want = expected_readings.pop_front();
            compare_field("raw_frame", 64'(want.frame), 64'(res_ch.raw_frame));
            compare_field("bits_received", 64'(want.nbits), 64'(res_ch.bits_received));
            compare_field("checksum_ok", 64'(want.ok), 64'(res_ch.checksum_ok));
            compare_field("frame_valid", 64'(want.valid), 64'(res_ch.frame_valid));
            compare_field("timed_out", 64'(want.tmo), 64'(res_ch.timed_out));
            compare_field("humidity_tenths", 64'(want.hum), 64'(res_ch.humidity_tenths));
            compare_field("temp_c_tenths", 64'(want.tc),
                          64'($unsigned(res_ch.temp_c_tenths)));
            compare_field("temp_f_tenths", 64'(want.tf),
                          64'($unsigned(res_ch.temp_f_tenths)));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            thr_reg = hspd_pkg::BIT_THRESHOLD_RST;
            tmo_reg = hspd_pkg::TIMEOUT_LIMIT_RST;
            edges_reg = hspd_pkg::MAX_EDGES_RST;
            busy = 1'b0;
            last_lvl = 1'b1;
            run_len = '0;
            edge_idx = '0;
            nbits = '0;
            frame_bits = '0;
            item_taken = 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    hspd_pkg::CFG_BIT_THRESHOLD: thr_reg = cfg_ch.data;
                    hspd_pkg::CFG_TIMEOUT_LIMIT: tmo_reg = cfg_ch.data;
                    hspd_pkg::CFG_MAX_EDGES:     edges_reg = cfg_ch.data;
                    default:                     ;
                endcase
            end
            item_taken = item_ch.valid && item_ch.ready;
            if (item_taken)
                decode_sample(item_ch.req_type, item_ch.pin_level);
            if (res_ch.valid && res_ch.ready)
                check_reading();
        end
    end

    always @(negedge clk)
    begin
        pin_item_t next_item;
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || item_taken)
        begin
            if (pin_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = pin_samples.pop_front();
                item_ch.valid <= 1'b1;
                item_ch.req_type <= next_item.req;
                item_ch.pin_level <= next_item.pin;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // A hold-off request blocks every result transfer while its countdown runs.
    always @(negedge clk)
    begin
        if (hold_grants != hold_requests)
        begin
            hold_left = hold_off_len;
            hold_grants = hold_requests;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_sample(input logic pin);
        pin_item_t it;
        it.req = hspd_pkg::REQ_SAMPLE;
        it.pin = pin;
        pin_samples.push_back(it);
    endtask

    task automatic push_start();
        pin_item_t it;
        it.req = hspd_pkg::REQ_START;
        it.pin = 1'($urandom_range(1));
        pin_samples.push_back(it);
    endtask

    task automatic push_run(input logic pin, input int n);
        push_sample(pin);
        repeat (n)
            push_sample(pin);
    endtask

    task automatic wait_quiet();
        do
            @(posedge clk);
        while (pin_samples.size() != 0 || item_ch.valid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [hspd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input int thr, input int tmo, input int edges);
        wait_quiet();
        write_reg(hspd_pkg::CFG_BIT_THRESHOLD, 8'(thr));
        write_reg(hspd_pkg::CFG_TIMEOUT_LIMIT, 8'(tmo));
        write_reg(hspd_pkg::CFG_MAX_EDGES, 8'(edges));
        thr_set = thr;
        tmo_set = tmo;
        edges_set = edges;
    endtask

    // A well-formed frame: three preamble levels, then forty high pulses whose width
    // carries the bit, then either further pulses ending in a long high level, or nothing.
    task automatic queue_frame();
        logic [15:0] hum_raw;
        logic [15:0] tmp_raw;
        logic [7:0]  chk;
        logic [39:0] bits;
        int          tmo_eff;
        int          lo_max;
        int          zero_max;
        int          one_lo;
        int          one_hi;
        int          extra;
        tmo_eff = (tmo_set == 0) ? 256 : tmo_set;
        lo_max = (tmo_eff - 1 < 1) ? tmo_eff - 1 : 1;
        zero_max = (thr_set < 1) ? thr_set : 1;
        one_lo = thr_set + 1;
        one_hi = (thr_set + 3 < tmo_eff - 1) ? thr_set + 3 : tmo_eff - 1;
        case ($urandom_range(5))
            0:       hum_raw = 16'h0000;
            1:       hum_raw = 16'h03E8;
            2:       hum_raw = 16'h03E9;
            3:       hum_raw = 16'hFFFF;
            4:       hum_raw = 16'($urandom_range(1000));
            default: hum_raw = 16'($urandom_range(16'hFFFF));
        endcase
        case ($urandom_range(7))
            0:       tmp_raw = 16'h04E2;
            1:       tmp_raw = 16'h04E3;
            2:       tmp_raw = 16'h84E2;
            3:       tmp_raw = 16'h84E3;
            4:       tmp_raw = 16'h8000;
            5:       tmp_raw = 16'h7FFF;
            6:       tmp_raw = {1'($urandom_range(1)), 15'($urandom_range(1250))};
            default: tmp_raw = 16'($urandom_range(16'hFFFF));
        endcase
        chk = hum_raw[15:8] + hum_raw[7:0] + tmp_raw[15:8] + tmp_raw[7:0];
        if ($urandom_range(4) == 0)
            chk = 8'($urandom_range(255));
        bits = {hum_raw, tmp_raw, chk};
        if (one_lo > one_hi)
            bits = '0;
        push_start();
        push_run(1'b0, $urandom_range(0, lo_max));
        push_run(1'b1, $urandom_range(0, lo_max));
        push_run(1'b0, $urandom_range(0, lo_max));
        for (int i = hspd_pkg::FRAME_W - 1; i >= 0; i--)
        begin
            push_run(1'b1, bits[i] ? $urandom_range(one_lo, one_hi)
                                   : $urandom_range(0, zero_max));
            push_run(1'b0, $urandom_range(0, lo_max));
        end
        if ($urandom_range(3) != 0)
        begin
            extra = ($urandom_range(3) == 0) ? 100 : $urandom_range(3);
            repeat (extra)
            begin
                push_run(1'b1, $urandom_range(0, lo_max));
                push_run(1'b0, $urandom_range(0, lo_max));
            end
            push_run(1'b1, tmo_eff);
        end
    endtask

    task automatic queue_noise_read();
        int tmo_eff;
        int runs;
        int len;
        tmo_eff = (tmo_set == 0) ? 256 : tmo_set;
        runs = $urandom_range(1, 5);
        if ($urandom_range(3) != 0)
            push_start();
        repeat (runs)
        begin
            if ($urandom_range(15) == 0)
                push_start();
            len = ($urandom_range(7) == 0) ? tmo_eff
                                           : $urandom_range(0, (tmo_eff < 3) ? tmo_eff : 3);
            push_run(1'($urandom_range(1)), len);
        end
    endtask

    task automatic run_phase(input int thr, input int tmo, input int edges, input int send,
                             input int stall, input int frames, input int noise);
        configure(thr, tmo, edges);
        send_idle_pct = send;
        stall_pct = stall;
        for (int n = 0; n < frames; n++)
        begin
            queue_frame();
            queue_noise_read();
        end
        // The sender pauses here until every expected reading has come back.
        wait_quiet();
        repeat (noise)
            queue_noise_read();
    endtask

    initial
    begin
        #4_000_000;
        $display("humidity_sensor_pulse_decoder_core test failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.req_type = hspd_pkg::REQ_SAMPLE;
        item_ch.pin_level = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = hspd_pkg::CFG_BIT_THRESHOLD;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Samples while no read is running are ignored.
        push_sample(1'b0);
        push_sample(1'b1);
        configure(0, 3, 6);
        write_reg(CFG_SPARE, 8'($urandom_range(255)));

        // A start during a read abandons it, then a steady level times out.
        push_start();
        push_sample(1'b1);
        push_start();
        push_sample(1'b1);
        push_sample(1'b1);
        push_sample(1'b1);
        // A short read that ends on the edge count after one data bit.
        push_start();
        push_sample(1'b0);
        push_sample(1'b1);
        push_sample(1'b0);
        push_sample(1'b1);
        push_sample(1'b1);
        push_sample(1'b0);
        push_sample(1'b1);
        push_sample(1'b0);

        run_phase(0, 3, 255, 0, 0, 1, 4);
        run_phase(1, 6, 84, 51, 0, 1, 4);
        run_phase(2, 8, 200, 0, 51, 1, 4);
        run_phase(5, 0, 0, 25, 25, 0, 4);
        run_phase(0, 1, 1, 25, 25, 0, 12);
        run_phase(254, 255, 90, 0, 0, 0, 2);

        // Short reads at full rate against a long receiver hold-off fill the block.
        configure(0, 200, 1);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_len = 300;
        hold_requests++;
        repeat (60)
        begin
            push_start();
            push_sample(1'b0);
        end
        wait_quiet();

        if (mismatches == 0)
            $display("humidity_sensor_pulse_decoder_core test passed");
        else
            $display("humidity_sensor_pulse_decoder_core test failed");
        $finish;
    end

endmodule
